[sv/aes_state_transform_unit_defines.svh]
// ----------------------------------------------------------------------------
// aes state transform unit assertion macros
// shared property wrappers for the unit's concurrent checks
// ----------------------------------------------------------------------------
`ifndef AES_STATE_TRANSFORM_UNIT_DEFINES_SVH
`define AES_STATE_TRANSFORM_UNIT_DEFINES_SVH

// implication checked every clock outside reset
`define AST_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define AST_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ast_pkg.sv]
// ----------------------------------------------------------------------------
// aes state transform package
// command codes, sbox tables and gf(2^8) helpers
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int unsigned NumLanes = 4;
    localparam int unsigned DataBits = 128;
    localparam int unsigned SDataBits = 264;
    localparam int unsigned MDataBits = 128;

    typedef enum logic [2:0] {
        CMD_ADD_KEY   = 3'd0,
        CMD_SUB       = 3'd1,
        CMD_SHIFT     = 3'd2,
        CMD_MIX       = 3'd3,
        CMD_INV_SUB   = 3'd4,
        CMD_INV_SHIFT = 3'd5,
        CMD_INV_MIX   = 3'd6,
        CMD_PASS      = 3'd7
    } cmd_t;

    typedef logic [7:0] byte_t;
    typedef byte_t [15:0] state_t;   // index k = state byte k
    typedef byte_t [3:0] column_t;

    // multiply by x
    function automatic byte_t gf_dbl(input byte_t a);
        gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // column products for the forward and inverse matrices
    function automatic column_t mix_col(input column_t s, input logic inv);
        byte_t x2 [4];
        byte_t x4 [4];
        byte_t x8 [4];
        byte_t m0 [4];
        byte_t m1 [4];
        byte_t m2 [4];
        byte_t m3 [4];
        column_t d;
        for (int j = 0; j < 4; j++) begin
            x2[j] = gf_dbl(s[j]);
            x4[j] = gf_dbl(x2[j]);
            x8[j] = gf_dbl(x4[j]);
            // coefficient 2/e, 3/b, 1/d, 1/9
            m0[j] = inv ? (x8[j] ^ x4[j] ^ x2[j]) : x2[j];
            m1[j] = inv ? (x8[j] ^ x2[j] ^ s[j]) : (x2[j] ^ s[j]);
            m2[j] = inv ? (x8[j] ^ x4[j] ^ s[j]) : s[j];
            m3[j] = inv ? (x8[j] ^ s[j]) : s[j];
        end
        for (int r = 0; r < 4; r++) begin
            d[r] = m0[r] ^ m1[(r + 1) % 4] ^ m2[(r + 2) % 4] ^ m3[(r + 3) % 4];
        end
        mix_col = d;
    endfunction

    function automatic byte_t fwd_sbox(input byte_t a);
        byte_t t [256] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        fwd_sbox = t[a];
    endfunction

    function automatic byte_t inv_sbox(input byte_t a);
        byte_t t [256] = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[a];
    endfunction

    // 128-bit bus (bits 127:120 = byte 0) to byte array
    function automatic state_t unpack_state(input logic [DataBits-1:0] v);
        state_t s;
        for (int k = 0; k < 16; k++) begin
            s[k] = v[DataBits-1-8*k -: 8];
        end
        unpack_state = s;
    endfunction

    function automatic logic [DataBits-1:0] pack_state(input state_t s);
        logic [DataBits-1:0] v;
        for (int k = 0; k < 16; k++) begin
            v[DataBits-1-8*k -: 8] = s[k];
        end
        pack_state = v;
    endfunction

endpackage

[sv/ast_lane.sv]
// ----------------------------------------------------------------------------
// aes state transform column lane
// transforms one four-byte column for every command but the row shifts
// ----------------------------------------------------------------------------
module ast_lane (
    input  ast_pkg::cmd_t    cmd,
    input  ast_pkg::column_t col_in,
    input  ast_pkg::column_t key_in,
    output ast_pkg::column_t col_out
);
    import ast_pkg::*;

    column_t sub_col;
    column_t inv_col;

    // byte substitution per row
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sub_col[r] = fwd_sbox(col_in[r]);
            inv_col[r] = inv_sbox(col_in[r]);
        end
    end

    // command select for this column
    always_comb begin
        case (cmd)
            CMD_ADD_KEY: col_out = col_in ^ key_in;
            CMD_SUB:     col_out = sub_col;
            CMD_INV_SUB: col_out = inv_col;
            CMD_MIX:     col_out = mix_col(col_in, 1'b0);
            CMD_INV_MIX: col_out = mix_col(col_in, 1'b1);
            default:     col_out = col_in;
        endcase
    end

endmodule

[sv/ast_merge.sv]
// ----------------------------------------------------------------------------
// aes state transform merge stage
// gathers lane columns and applies the row shifts across columns
// ----------------------------------------------------------------------------
module ast_merge (
    input  ast_pkg::cmd_t   cmd,
    input  ast_pkg::state_t state_in,
    input  ast_pkg::state_t lane_in,
    output ast_pkg::state_t state_out
);
    import ast_pkg::*;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            case (cmd)
                CMD_SHIFT:
                    state_out[i] = state_in[(((i >> 2) + (i & 3)) & 3) * 4 + (i & 3)];
                CMD_INV_SHIFT:
                    state_out[i] = state_in[(((i >> 2) - (i & 3) + 4) & 3) * 4 + (i & 3)];
                default:
                    state_out[i] = lane_in[i];
            endcase
        end
    end

endmodule

[sv/aes_state_transform_unit.sv]
// ----------------------------------------------------------------------------
// aes state transform unit
// one aes-128 round transformation per word, selected by command
// ----------------------------------------------------------------------------
// Takes one word per cycle unless the output stalls and returns the transformed
// state in the cycle after acceptance; four column lanes (sbox, mix, key add)
// feed a merge stage that also does row shifts; one output register holds it.
// The input is taken whenever the output register is empty or being drained.
// s_axis_tdata: command[2:0], state_hi[66:3], state_lo[130:67],
// key_hi[194:131], key_lo[258:195] (lowest bit first, zero filled).
module aes_state_transform_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // command, state_hi, state_lo, key_hi, key_lo from bit 0 up
    input  logic [ast_pkg::SDataBits-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_hi, result_lo from bit 0 up
    output logic [ast_pkg::MDataBits-1:0] m_axis_tdata
);
    import ast_pkg::*;
    `include "aes_state_transform_unit_defines.svh"

    cmd_t   cmd;
    state_t st;
    state_t key;
    state_t lane_out;
    state_t merged;
    logic   valid_reg;
    logic   accept;
    logic [DataBits-1:0] data_reg;
    logic [DataBits-1:0] data_next;

    // field extraction
    assign cmd = cmd_t'(s_axis_tdata[2:0]);
    assign st  = unpack_state({s_axis_tdata[66:3], s_axis_tdata[130:67]});
    assign key = unpack_state({s_axis_tdata[194:131], s_axis_tdata[258:195]});

    // column lanes
    for (genvar c = 0; c < NumLanes; c++) begin : g_lane
        ast_lane u_lane (
            .cmd    (cmd),
            .col_in (st[4*c +: 4]),
            .key_in (key[4*c +: 4]),
            .col_out(lane_out[4*c +: 4])
        );
    end

    ast_merge u_merge (
        .cmd      (cmd),
        .state_in (st),
        .lane_in  (lane_out),
        .state_out(merged)
    );

    // output register handshake
    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign data_next     = pack_state(merged);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg[63:0], data_reg[127:64]};

    `AST_ASSERT_NXT(a_accept_valid, aclk, aresetn, accept, m_axis_tvalid)
    `AST_ASSERT_NXT(a_hold_stall, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `AST_ASSERT_IMP(a_ready_free, aclk, aresetn, !m_axis_tvalid, s_axis_tready)

endmodule

[sim/aes_state_transform_unit_checker.sv]
// ----------------------------------------------------------------------------
// aes state transform unit checker
// watches both stream channels, predicts each transformed state and compares
// ----------------------------------------------------------------------------
module aes_state_transform_unit_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [263:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    output int           mismatches,
    output int           states_pending,
    output int           states_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ast_pkg::*;

    typedef logic [7:0] octet_t;

    octet_t         sub_lut [256];
    octet_t         inv_sub_lut [256];
    logic [127:0]   state_queue [$];

    // gf(2^8) product, walking the bits of b
    function automatic octet_t gf_times(input octet_t a, input octet_t b);
        octet_t acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // substitution tables from the field inverse and the affine map
    initial begin
        octet_t inv_v;
        octet_t sb;
        for (int a = 0; a < 256; a++) begin
            inv_v = 8'h01;
            for (int e = 0; e < 254; e++) inv_v = gf_times(inv_v, octet_t'(a));
            if (a == 0) inv_v = 8'h00;
            sb = inv_v ^ {inv_v[6:0], inv_v[7]} ^ {inv_v[5:0], inv_v[7:6]}
                 ^ {inv_v[4:0], inv_v[7:5]} ^ {inv_v[3:0], inv_v[7:4]} ^ 8'h63;
            sub_lut[a] = sb;
            inv_sub_lut[sb] = octet_t'(a);
        end
    end

    // expected 128-bit state {hi, lo} for one input word
    function automatic logic [127:0] transform_state(input cmd_t cmd,
                                                     input logic [127:0] st,
                                                     input logic [127:0] rk);
        octet_t s [16];
        octet_t k [16];
        octet_t d [16];
        octet_t coef [4];
        logic [127:0] v;
        int r;
        int c;
        for (int i = 0; i < 16; i++) begin
            s[i] = st[127-8*i -: 8];
            k[i] = rk[127-8*i -: 8];
        end
        if (cmd == CMD_MIX)
            coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        else
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int i = 0; i < 16; i++) begin
            r = i % 4;
            c = i / 4;
            case (cmd) inside
                CMD_ADD_KEY:   d[i] = s[i] ^ k[i];
                CMD_SUB:       d[i] = sub_lut[s[i]];
                CMD_SHIFT:     d[i] = s[((c + r) % 4) * 4 + r];
                CMD_INV_SUB:   d[i] = inv_sub_lut[s[i]];
                CMD_INV_SHIFT: d[i] = s[((c - r + 4) % 4) * 4 + r];
                CMD_MIX, CMD_INV_MIX: begin
                    d[i] = 8'h00;
                    for (int j = 0; j < 4; j++)
                        d[i] ^= gf_times(s[c*4 + j], coef[(j - r + 4) % 4]);
                end
                default:       d[i] = s[i];
            endcase
        end
        for (int i = 0; i < 16; i++) v[127-8*i -: 8] = d[i];
        return v;
    endfunction

    // predict on input words, compare on result words
    always @(posedge aclk) begin
        logic [127:0] want;
        logic [127:0] got;
        if (!aresetn) begin
            mismatches     <= 0;
            states_checked <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                state_queue.push_back(transform_state(cmd_t'(s_axis_tdata[2:0]),
                    {s_axis_tdata[66:3], s_axis_tdata[130:67]},
                    {s_axis_tdata[194:131], s_axis_tdata[258:195]}));
            if (m_axis_tvalid && m_axis_tready) begin
                states_checked <= states_checked + 1;
                got = {m_axis_tdata[63:0], m_axis_tdata[127:64]};
                if (state_queue.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = state_queue.pop_front();
                    if (got[127:64] !== want[127:64] || got[63:0] !== want[63:0]) begin
                        $display("%0t: result mismatch hi exp %h got %h, lo exp %h got %h",
                                 $time, want[127:64], got[127:64], want[63:0], got[63:0]);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        states_pending <= state_queue.size();
    end
endmodule

[sim/aes_state_transform_unit_tb.sv]
// ----------------------------------------------------------------------------
// aes state transform unit testbench
// drives directed and random state words with random stalls on both sides
// ----------------------------------------------------------------------------
module aes_state_transform_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ast_pkg::*;

    localparam int RANDOM_WORDS = 1950;
    localparam int STALL_LIMIT  = 2000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         steady_flow = 1'b0;
    int           mismatches;
    int           states_pending;
    int           states_checked;
    int           words_sent = 0;
    int           idle_cycles = 0;

    always #10 aclk = ~aclk;

    aes_state_transform_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    aes_state_transform_unit_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .mismatches(mismatches), .states_pending(states_pending),
        .states_checked(states_checked)
    );

    // result side backpressure
    always @(posedge aclk) begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 23);
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (aresetn)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("** aes_state_transform_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one word, held until taken; valid stays high into the next word unless a random gap is inserted
    task automatic send_word(input cmd_t cmd, input logic [63:0] st_hi,
                             input logic [63:0] st_lo, input logic [63:0] k_hi,
                             input logic [63:0] k_lo);
        logic rdy;
        while (!steady_flow && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, k_lo, k_hi, st_lo, st_hi, cmd};
        do begin
            @(negedge aclk);
            rdy = s_axis_tready;
            @(posedge aclk);
        end while (!rdy);
        words_sent++;
    endtask

    initial begin
        cmd_t cmd;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every command on an all-zero and an all-one state, then known round states
        for (int c = 0; c < 8; c++) begin
            cmd = cmd_t'(c);
            send_word(cmd, 64'h0, 64'h0, 64'hffff_ffff_ffff_ffff, 64'h0);
            send_word(cmd, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                      64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        end
        send_word(CMD_MIX, 64'hdbf2_01c6_13d9_c0e3, 64'h53a0_a89e_455d_ce35, '0, '0);
        send_word(CMD_INV_MIX, 64'h8e9f_01c6_4ddc_c0e3, 64'ha1a0_a8bc_4d58_ce12, '0, '0);
        send_word(CMD_SHIFT, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, '0, '0);
        send_word(CMD_INV_SHIFT, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                  '0, '0);
        send_word(CMD_ADD_KEY, 64'h3243_f6a8_885a_308d, 64'h3131_98a2_e037_0734,
                  64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c);
        send_word(CMD_PASS, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                  64'hffff_ffff_ffff_ffff, 64'h5555_aaaa_5555_aaaa);

        // random commands and states, with a stretch of full throughput
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady_flow <= (n >= 700 && n < 1000);
            send_word(cmd_t'($urandom_range(7)), rand64(), rand64(), rand64(), rand64());
        end
        s_axis_tvalid <= 1'b0;
        steady_flow   <= 1'b0;

        // drain
        while (states_pending != 0 || states_checked != words_sent) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("sent %0d state words over all eight commands, checked %0d results",
                 words_sent, states_checked);
        $display("stalls on both channels, one stretch at full rate");
        if (mismatches == 0)
            $display("** aes_state_transform_unit: PASSED **");
        else
            $display("** aes_state_transform_unit: FAILED **");
        $finish;
    end
endmodule
